/* design/cswg_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// Shared constants, types, divider step functions and coefficient lookup of the window generator.
package cswg_pkg;

   localparam int MAX_LENGTH = 4096;
   localparam int FRAC_BITS  = 16;
   localparam int IDX_W      = 13;
   localparam int VAL_W      = 20;
   localparam int KIND_W     = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int N_TERMS    = 7;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_KIND   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_LENGTH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TRIANGLE_SUB  = 2'd2;

   // window kinds
   localparam logic [KIND_W-1:0] KIND_HAMMING  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_HANN     = 3'd1;
   localparam logic [KIND_W-1:0] KIND_BH4      = 3'd2;
   localparam logic [KIND_W-1:0] KIND_BH7      = 3'd3;
   localparam logic [KIND_W-1:0] KIND_FLATTOP  = 3'd4;
   localparam logic [KIND_W-1:0] KIND_TRIANGLE = 3'd5;

   localparam logic [KIND_W-1:0] KIND_RESET = KIND_HAMMING;
   localparam logic [IDX_W-1:0]  LEN_RESET  = 13'd64;
   localparam logic [IDX_W-1:0]  SUB_RESET  = 13'd64;

   // phase divider: (k*n << 32) / (N-1), low 32 quotient bits
   localparam int PH_DVD_W  = 48;
   localparam int PH_QUO_W  = 32;
   localparam int PH_STEPS  = 8;
   localparam int PH_STAGES = PH_DVD_W / PH_STEPS;

   // cosine evaluation
   localparam int HORNER_STEPS = 7;
   localparam int COS_STAGES   = 2 + 3 * HORNER_STEPS;
   localparam logic [30:0]        HALF_PI_Q30 = 31'd1686629713;
   localparam logic signed [31:0] Q30_ONE     = 32'sh4000_0000;
   localparam logic [7:0] HORNER_DIV [HORNER_STEPS] =
      '{8'd182, 8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};
   localparam logic [31:0] HORNER_RECIP [HORNER_STEPS] = '{
      32'((64'd1 << 32) / 64'd182), 32'((64'd1 << 32) / 64'd132),
      32'((64'd1 << 32) / 64'd90),  32'((64'd1 << 32) / 64'd56),
      32'((64'd1 << 32) / 64'd30),  32'((64'd1 << 32) / 64'd12),
      32'((64'd1 << 32) / 64'd2)};

   // coefficients in units of 1e-5
   localparam int COEF_W = 19;
   localparam logic signed [COEF_W-1:0] COEF_TAB [5][N_TERMS] = '{
      '{19'sd53836, -19'sd46164, 19'sd0, 19'sd0, 19'sd0, 19'sd0, 19'sd0},
      '{19'sd50000, -19'sd50000, 19'sd0, 19'sd0, 19'sd0, 19'sd0, 19'sd0},
      '{19'sd35875, -19'sd48829, 19'sd14128, -19'sd1168, 19'sd0, 19'sd0, 19'sd0},
      '{19'sd27105, -19'sd43329, 19'sd21812, -19'sd6592, 19'sd1081, -19'sd77,
        19'sd1},
      '{19'sd100000, -19'sd193000, 19'sd129000, -19'sd38800, 19'sd2800, 19'sd0,
        19'sd0}};

   // rounding of the coefficient sum
   localparam int ROUND_SHIFT = 30 - FRAC_BITS;
   localparam logic [52:0] ROUND_HALF = 53'((64'd100000 << ROUND_SHIFT) / 64'd2);

   // final rounding divider
   localparam int FD_DIV_W  = 17;
   localparam int FD_DVD_W  = 40;
   localparam int FD_Q_W    = 20;
   localparam int FD_STEPS  = 4;
   localparam int FD_STAGES = FD_Q_W / FD_STEPS;
   localparam logic [FD_DIV_W-1:0] COS_DIVISOR = 17'd100000;

   localparam logic signed [VAL_W-1:0] VAL_MAX = 20'sh7FFFF;
   localparam logic signed [VAL_W-1:0] VAL_MIN = 20'sh80000;

   // stage 0 entry, phase, cosine, product/sum/sum, prep, divider, output
   localparam int SB_DEPTH   = 1 + PH_STAGES + COS_STAGES + 3;
   localparam int PIPE_DEPTH = SB_DEPTH + 1 + FD_STAGES;
   localparam int LATENCY    = PIPE_DEPTH + 1;

   typedef struct packed {
      logic [IDX_W-1:0]    rem;
      logic [PH_DVD_W-1:0] dvd;
      logic [PH_QUO_W-1:0] quo;
   } phase_div_type;

   typedef struct packed {
      logic [FD_DIV_W-1:0] rem;
      logic [FD_Q_W-1:0]   dvd;
      logic [FD_Q_W-1:0]   quo;
      logic                neg;
      logic                err;
   } final_div_type;

   function automatic phase_div_type phase_steps(phase_div_type s, logic [IDX_W-1:0] m);
      phase_div_type r;
      logic [IDX_W:0] acc;
      r = s;
      for (int i = 0; i < PH_STEPS; i++) begin
         acc   = {r.rem, r.dvd[PH_DVD_W-1]};
         r.dvd = {r.dvd[PH_DVD_W-2:0], 1'b0};
         if (acc >= {1'b0, m}) begin
            acc   = acc - {1'b0, m};
            r.quo = {r.quo[PH_QUO_W-2:0], 1'b1};
         end else begin
            r.quo = {r.quo[PH_QUO_W-2:0], 1'b0};
         end
         r.rem = acc[IDX_W-1:0];
      end
      return r;
   endfunction

   function automatic final_div_type final_steps(final_div_type s,
                                                 logic [FD_DIV_W-1:0] dv);
      final_div_type r;
      logic [FD_DIV_W:0] acc;
      r = s;
      for (int i = 0; i < FD_STEPS; i++) begin
         acc   = {r.rem, r.dvd[FD_Q_W-1]};
         r.dvd = {r.dvd[FD_Q_W-2:0], 1'b0};
         if (acc >= {1'b0, dv}) begin
            acc   = acc - {1'b0, dv};
            r.quo = {r.quo[FD_Q_W-2:0], 1'b1};
         end else begin
            r.quo = {r.quo[FD_Q_W-2:0], 1'b0};
         end
         r.rem = acc[FD_DIV_W-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [COEF_W-1:0] coef_of(logic [KIND_W-1:0] kind,
                                                       logic [2:0] term);
      logic signed [COEF_W-1:0] c;
      c = '0;
      if (kind <= KIND_FLATTOP && term < 3'(N_TERMS)) begin
         c = COEF_TAB[kind][term];
      end
      return c;
   endfunction

endpackage
`default_nettype wire

/* design/cswg_cos_lane.sv */
`timescale 1ns / 1ps
`default_nettype none
// One cosine term: phase divider, angle scaling and Horner series, fully pipelined.
module cswg_cos_lane #(
   parameter int TERM = 1
) (
   input  wire logic                          clock,
   input  wire logic [cswg_pkg::IDX_W-1:0]    sample_index,
   input  wire logic [cswg_pkg::IDX_W-1:0]    period,
   output logic signed [31:0]                 cos_value
);

   localparam int HS_LAST = 3 * cswg_pkg::HORNER_STEPS;

   typedef struct packed {
      logic [1:0]         quad;
      logic [31:0]        x2;
      logic [31:0]        q;
      logic [31:0]        est;
      logic signed [31:0] t;
   } horner_type;

   cswg_pkg::phase_div_type ph_ff [cswg_pkg::PH_STAGES];
   cswg_pkg::phase_div_type ph_in [cswg_pkg::PH_STAGES];
   logic [30:0]  x_ff, x_in;
   logic [1:0]   quad_ff, quad_in;
   horner_type   hs_ff [HS_LAST+1];
   horner_type   hs_in [HS_LAST+1];
   logic [15:0]  term_index;

   assign term_index = 16'(TERM) * {3'b0, sample_index};

   always_comb begin
      ph_in[0] = cswg_pkg::phase_steps('{rem: '0, dvd: {term_index, 32'b0}, quo: '0},
                                       period);
      for (int s = 1; s < cswg_pkg::PH_STAGES; s++) begin
         ph_in[s] = cswg_pkg::phase_steps(ph_ff[s-1], period);
      end
   end

   // fold the turn fraction into the first quadrant, scale to radians
   always_comb begin
      logic [31:0] phase;
      logic [30:0] fold;
      logic [61:0] xp;
      phase   = ph_ff[cswg_pkg::PH_STAGES-1].quo;
      fold    = phase[30] ? (31'h4000_0000 - {1'b0, phase[29:0]}) : {1'b0, phase[29:0]};
      xp      = 62'(fold) * 62'(cswg_pkg::HALF_PI_Q30);
      x_in    = xp[60:30];
      quad_in = phase[31:30];
   end

   always_comb begin
      logic [61:0] sq;
      logic [62:0] mq;
      logic [63:0] me;
      logic [39:0] back;
      logic [39:0] rem;
      logic [31:0] qq;
      int j;
      sq = 62'(x_ff) * 62'(x_ff);
      hs_in[0] = '{quad: quad_ff, x2: sq[61:30], q: '0, est: '0, t: cswg_pkg::Q30_ONE};
      for (int h = 0; h < cswg_pkg::HORNER_STEPS; h++) begin
         j = 1 + 3 * h;
         hs_in[j]   = hs_ff[j-1];
         mq         = 63'(hs_ff[j-1].x2) * 63'(hs_ff[j-1].t[30:0]);
         hs_in[j].q = mq[61:30];

         hs_in[j+1]     = hs_ff[j];
         me             = 64'(hs_ff[j].q) * 64'(cswg_pkg::HORNER_RECIP[h]);
         hs_in[j+1].est = me[63:32];

         // reciprocal estimate is low by at most one: correct it
         hs_in[j+2]   = hs_ff[j+1];
         back         = 40'(hs_ff[j+1].est) * 40'(cswg_pkg::HORNER_DIV[h]);
         rem          = 40'(hs_ff[j+1].q) - back;
         qq           = hs_ff[j+1].est + 32'(rem >= 40'(cswg_pkg::HORNER_DIV[h]));
         hs_in[j+2].t = cswg_pkg::Q30_ONE - $signed(qq);
      end
   end

   always_ff @(posedge clock) begin
      ph_ff   <= ph_in;
      x_ff    <= x_in;
      quad_ff <= quad_in;
      hs_ff   <= hs_in;
   end

   assign cos_value = (hs_ff[HS_LAST].quad == 2'd1 || hs_ff[HS_LAST].quad == 2'd2) ?
                      -hs_ff[HS_LAST].t : hs_ff[HS_LAST].t;

endmodule
`default_nettype wire

/* design/cosine_sum_window_generator.sv */
`timescale 1ns / 1ps
`default_nettype none
// Top level of the cosine-sum and triangular window coefficient generator.
//
//  channel    ports                                        handshake
//  request    start, busy, req_sample_index                start & !busy
//  result     rsp_valid, rsp_window_value, rsp_range_error one-cycle strobe
//  config     csr_wr_en, csr_index, csr_wdata              write on csr_wr_en
//
// One request per cycle while busy is low. Depth is set by the 48-step phase divider,
// the seven-step Horner series and the 20-step rounding divider. Synchronous reset
// clears the configuration and all valid bits; busy is high only while reset is held.
// Results cannot be held off, so nothing ever stalls.
module cosine_sum_window_generator (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic [cswg_pkg::IDX_W-1:0]        req_sample_index,
   output logic                                   rsp_valid,
   output logic signed [cswg_pkg::VAL_W-1:0]      rsp_window_value,
   output logic                                   rsp_range_error,
   input  wire logic                              csr_wr_en,
   input  wire logic [cswg_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [cswg_pkg::IDX_W-1:0]        csr_wdata
);

   typedef struct packed {
      logic        err;
      logic        tneg;
      logic [14:0] tmag;
   } sideband_type;

   typedef struct packed {
      logic [cswg_pkg::FD_DVD_W-1:0] dvd;
      logic                          neg;
      logic                          err;
   } prep_type;

   logic [cswg_pkg::KIND_W-1:0] kind_ff;
   logic [cswg_pkg::IDX_W-1:0]  len_ff;
   logic [cswg_pkg::IDX_W-1:0]  sub_ff;
   logic [cswg_pkg::IDX_W-1:0]  period;
   logic                        accept;

   logic [cswg_pkg::PIPE_DEPTH-1:0] valid_ff;
   logic [cswg_pkg::IDX_W-1:0]      n_ff;
   sideband_type                    sb_ff [cswg_pkg::SB_DEPTH];
   sideband_type                    sb_in;

   logic signed [31:0] cos_term [cswg_pkg::N_TERMS];
   logic signed [50:0] prod_ff [cswg_pkg::N_TERMS];
   logic signed [50:0] prod_in [cswg_pkg::N_TERMS];
   logic signed [51:0] pair_ff [4];
   logic signed [51:0] pair_in [4];
   logic signed [52:0] total_ff, total_in;
   prep_type           prep_ff, prep_in;

   cswg_pkg::final_div_type        fd_ff [cswg_pkg::FD_STAGES];
   cswg_pkg::final_div_type        fd_in [cswg_pkg::FD_STAGES];
   logic [cswg_pkg::FD_DIV_W-1:0]  divisor;

   logic                               rsp_valid_ff;
   logic signed [cswg_pkg::VAL_W-1:0]  rsp_value_ff, rsp_value_in;
   logic                               rsp_error_ff;

   assign busy   = reset;
   assign accept = start & ~busy;
   assign period = len_ff - 13'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= cswg_pkg::KIND_RESET;
         len_ff  <= cswg_pkg::LEN_RESET;
         sub_ff  <= cswg_pkg::SUB_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            cswg_pkg::CSR_WINDOW_KIND:   kind_ff <= csr_wdata[cswg_pkg::KIND_W-1:0];
            cswg_pkg::CSR_WINDOW_LENGTH: len_ff  <= csr_wdata;
            cswg_pkg::CSR_TRIANGLE_SUB:  sub_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // request checks and triangular numerator
   always_comb begin
      logic [13:0]        len14;
      logic [13:0]        sub14;
      logic               sub_ok;
      logic signed [14:0] d;
      logic [14:0]        ad;
      logic signed [15:0] num;
      len14  = {1'b0, len_ff};
      sub14  = {1'b0, sub_ff};
      sub_ok = (sub_ff != '0) &&
               (sub14 == len14 - 14'd1 || sub14 == len14 || sub14 == len14 + 14'd1);
      sb_in.err = (req_sample_index > len_ff) ||
                  ({19'b0, len_ff} > 32'(cswg_pkg::MAX_LENGTH)) ||
                  (kind_ff > cswg_pkg::KIND_TRIANGLE) ||
                  ((kind_ff == cswg_pkg::KIND_TRIANGLE) ? !sub_ok : (len_ff < 13'd2));
      d  = $signed({1'b0, req_sample_index, 1'b0}) - $signed({2'b0, len_ff}) + 15'sd1;
      ad = d[14] ? 15'(-d) : 15'(d);
      num = $signed({3'b0, sub_ff}) - $signed({1'b0, ad});
      sb_in.tneg = num[15];
      sb_in.tmag = num[15] ? 15'(-num) : 15'(num);
   end

   generate
      for (genvar k = 1; k < cswg_pkg::N_TERMS; k++) begin : g_lane
         cswg_cos_lane #(
            .TERM(k)
         ) u_lane (
            .clock        (clock),
            .sample_index (n_ff),
            .period       (period),
            .cos_value    (cos_term[k])
         );
      end
   endgenerate

   assign cos_term[0] = cswg_pkg::Q30_ONE;

   always_comb begin
      for (int k = 0; k < cswg_pkg::N_TERMS; k++) begin
         prod_in[k] = 51'(cswg_pkg::coef_of(kind_ff, 3'(k))) * 51'(cos_term[k]);
      end
      pair_in[0] = 52'(prod_ff[0]) + 52'(prod_ff[1]);
      pair_in[1] = 52'(prod_ff[2]) + 52'(prod_ff[3]);
      pair_in[2] = 52'(prod_ff[4]) + 52'(prod_ff[5]);
      pair_in[3] = 52'(prod_ff[6]);
      total_in   = 53'(pair_ff[0]) + 53'(pair_ff[1]) + 53'(pair_ff[2]) + 53'(pair_ff[3]);
   end

   // pick the rounding dividend: coefficient sum or triangular ratio
   always_comb begin
      logic [52:0]  mag;
      logic [52:0]  rounded;
      sideband_type sb;
      sb      = sb_ff[cswg_pkg::SB_DEPTH-1];
      mag     = total_ff[52] ? 53'(-total_ff) : 53'(total_ff);
      rounded = mag + cswg_pkg::ROUND_HALF;
      prep_in.err = sb.err;
      if (kind_ff == cswg_pkg::KIND_TRIANGLE) begin
         prep_in.dvd = (40'(sb.tmag) << cswg_pkg::FRAC_BITS) + 40'(sub_ff >> 1);
         prep_in.neg = sb.tneg;
      end else begin
         prep_in.dvd = 40'(rounded >> cswg_pkg::ROUND_SHIFT);
         prep_in.neg = total_ff[52];
      end
   end

   assign divisor = (kind_ff == cswg_pkg::KIND_TRIANGLE) ? {4'b0, sub_ff} :
                    cswg_pkg::COS_DIVISOR;

   always_comb begin
      fd_in[0] = cswg_pkg::final_steps('{rem: prep_ff.dvd[36:20], dvd: prep_ff.dvd[19:0],
                                          quo: '0, neg: prep_ff.neg, err: prep_ff.err},
                                       divisor);
      for (int s = 1; s < cswg_pkg::FD_STAGES; s++) begin
         fd_in[s] = cswg_pkg::final_steps(fd_ff[s-1], divisor);
      end
   end

   // apply sign, saturate, drop the value on error
   always_comb begin
      logic [cswg_pkg::FD_Q_W-1:0] q;
      q = fd_ff[cswg_pkg::FD_STAGES-1].quo;
      if (fd_ff[cswg_pkg::FD_STAGES-1].err) begin
         rsp_value_in = '0;
      end else if (fd_ff[cswg_pkg::FD_STAGES-1].neg) begin
         rsp_value_in = (q > 20'd524288) ? cswg_pkg::VAL_MIN : $signed(-q);
      end else begin
         rsp_value_in = (q > 20'd524287) ? cswg_pkg::VAL_MAX : $signed(q);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= {valid_ff[cswg_pkg::PIPE_DEPTH-2:0], accept};
         rsp_valid_ff <= valid_ff[cswg_pkg::PIPE_DEPTH-1];
      end
   end

   always_ff @(posedge clock) begin
      n_ff     <= req_sample_index;
      sb_ff[0] <= sb_in;
      for (int s = 1; s < cswg_pkg::SB_DEPTH; s++) begin
         sb_ff[s] <= sb_ff[s-1];
      end
      prod_ff      <= prod_in;
      pair_ff      <= pair_in;
      total_ff     <= total_in;
      prep_ff      <= prep_in;
      fd_ff        <= fd_in;
      rsp_value_ff <= rsp_value_in;
      rsp_error_ff <= fd_ff[cswg_pkg::FD_STAGES-1].err;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_window_value = rsp_value_ff;
   assign rsp_range_error  = rsp_error_ff;

endmodule
`default_nettype wire

/* design/cswg_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// Port-level checks of the window generator and their binding.
module cswg_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              start,
   input wire logic                              busy,
   input wire logic                              rsp_valid,
   input wire logic signed [cswg_pkg::VAL_W-1:0] rsp_window_value,
   input wire logic                              rsp_range_error
);

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_range_error |-> rsp_window_value == '0)
      else $error("error result carries a nonzero value");

   a_fixed_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, cswg_pkg::LATENCY))
      else $error("result without a request at the pipeline latency");

   a_reset_flush: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result strobe right after reset");

   a_busy_reset: assert property (@(posedge clock)
      busy |-> reset)
      else $error("busy outside reset");

endmodule

bind cosine_sum_window_generator cswg_checker u_cswg_checker (.*);
`default_nettype wire

/* sim/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench of the cosine-sum and triangular window generator.
module tb;

   typedef struct packed {
      logic signed [cswg_pkg::VAL_W-1:0] value;
      logic                              err;
   } coef_result_type;

   class window_scoreboard;
      logic [cswg_pkg::KIND_W-1:0] kind;
      logic [cswg_pkg::IDX_W-1:0]  len;
      logic [cswg_pkg::IDX_W-1:0]  sub;
      coef_result_type             pending[$];
      int                          mismatches;
      int                          checked;
      int                          errs_seen;

      function new();
         kind = cswg_pkg::KIND_RESET;
         len  = cswg_pkg::LEN_RESET;
         sub  = cswg_pkg::SUB_RESET;
      endfunction

      function automatic longint mul_q30(longint a, longint b);
         longint unsigned ua, ub, p;
         ua = a < 0 ? -a : a;
         ub = b < 0 ? -b : b;
         p  = (ua * ub) >> 30;
         return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
      endfunction

      function automatic longint div_round(longint num, longint den);
         longint unsigned q, un;
         un = num < 0 ? -num : num;
         q  = (un + longint'(den / 2)) / den;
         return num < 0 ? -longint'(q) : longint'(q);
      endfunction

      // cosine of a turn fraction in Q30, truncated Taylor series
      function automatic longint cos_of_turn(logic [31:0] p);
         longint f, x, x2, t;
         longint divs[7];
         divs = '{182, 132, 90, 56, 30, 12, 2};
         f = p[29:0];
         if (p[30]) f = (longint'(1) << 30) - f;
         x  = longint'((longint'(f) * longint'(cswg_pkg::HALF_PI_Q30)) >>> 30);
         x2 = mul_q30(x, x);
         t  = longint'(1) << 30;
         for (int i = 0; i < 7; i++) t = (longint'(1) << 30) - mul_q30(x2, t) / divs[i];
         return (p[31:30] == 2'd1 || p[31:30] == 2'd2) ? -t : t;
      endfunction

      function automatic coef_result_type window_at(logic [cswg_pkg::IDX_W-1:0] idx);
         longint coefs[5][7];
         int     nterms[5];
         longint n, l, s, v, d, sum;
         longint unsigned m, r;
         logic [31:0] p;
         coef_result_type res;
         coefs = '{'{53836, -46164, 0, 0, 0, 0, 0},
                   '{50000, -50000, 0, 0, 0, 0, 0},
                   '{35875, -48829, 14128, -1168, 0, 0, 0},
                   '{27105, -43329, 21812, -6592, 1081, -77, 1},
                   '{100000, -193000, 129000, -38800, 2800, 0, 0}};
         nterms = '{2, 2, 4, 7, 5};
         n = idx; l = len; s = sub; v = 0;
         res.err = 1'b0;
         if (n > l || l > cswg_pkg::MAX_LENGTH || kind > cswg_pkg::KIND_TRIANGLE) begin
            res.err = 1'b1;
         end else if (kind == cswg_pkg::KIND_TRIANGLE) begin
            if (s == 0 || (s != l - 1 && s != l && s != l + 1)) begin
               res.err = 1'b1;
            end else begin
               d = 2 * n - l + 1;
               v = div_round((s - (d < 0 ? -d : d)) * (longint'(1) << cswg_pkg::FRAC_BITS),
                             s);
            end
         end else if (l < 2) begin
            res.err = 1'b1;
         end else begin
            m = l - 1;
            sum = 0;
            for (int k = 0; k < nterms[kind]; k++) begin
               r   = (longint'(k) * n) % m;
               p   = 32'((r << 32) / m);
               sum += coefs[kind][k] * cos_of_turn(p);
            end
            v = div_round(sum, longint'(100000) << (30 - cswg_pkg::FRAC_BITS));
         end
         if (res.err) v = 0;
         if (v > 524287) v = 524287;
         if (v < -524288) v = -524288;
         res.value = v[cswg_pkg::VAL_W-1:0];
         return res;
      endfunction

      function void note_request(logic [cswg_pkg::IDX_W-1:0] idx);
         pending.push_back(window_at(idx));
      endfunction

      task report_mismatch(string what);
         mismatches++;
         $display("MISMATCH at %0t: %s", $time, what);
      endtask

      task check_result(logic signed [cswg_pkg::VAL_W-1:0] value, logic err);
         coef_result_type want;
         checked++;
         if (err) errs_seen++;
         if (pending.size() == 0) begin
            report_mismatch($sformatf("unexpected result value=%0d err=%0b", value, err));
         end else begin
            want = pending.pop_front();
            if (value !== want.value)
               report_mismatch($sformatf("window_value %0d, want %0d", value, want.value));
            if (err !== want.err)
               report_mismatch($sformatf("range_error %0b, want %0b", err, want.err));
         end
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [cswg_pkg::IDX_W-1:0] req_sample_index = '0;
   logic rsp_valid;
   logic signed [cswg_pkg::VAL_W-1:0] rsp_window_value;
   logic rsp_range_error;
   logic csr_wr_en = 1'b0;
   logic [cswg_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [cswg_pkg::IDX_W-1:0] csr_wdata = '0;

   window_scoreboard sb = new();
   longint cycles = 0;
   int sent = 0;
   int idle_pct = 0;
   localparam longint CYCLE_LIMIT = 400000;

   cosine_sum_window_generator i_dut (
      .clock, .reset, .start, .busy, .req_sample_index,
      .rsp_valid, .rsp_window_value, .rsp_range_error,
      .csr_wr_en, .csr_index, .csr_wdata
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("end of test: mismatches");
         $finish;
      end
      if (!reset) begin
         if (start && !busy) sb.note_request(req_sample_index);
         if (rsp_valid) sb.check_result(rsp_window_value, rsp_range_error);
      end
   end

   // drive one register write; the caller drops the write enable afterwards
   task write_csr(logic [cswg_pkg::CSR_IDX_W-1:0] idx, logic [cswg_pkg::IDX_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      if (idx == cswg_pkg::CSR_WINDOW_KIND) sb.kind = data[cswg_pkg::KIND_W-1:0];
      else if (idx == cswg_pkg::CSR_WINDOW_LENGTH) sb.len = data;
      else if (idx == cswg_pkg::CSR_TRIANGLE_SUB) sb.sub = data;
   endtask

   task configure(logic [cswg_pkg::KIND_W-1:0] kind, logic [cswg_pkg::IDX_W-1:0] len,
                  logic [cswg_pkg::IDX_W-1:0] sub);
      write_csr(cswg_pkg::CSR_WINDOW_KIND, cswg_pkg::IDX_W'(kind));
      write_csr(cswg_pkg::CSR_WINDOW_LENGTH, len);
      write_csr(cswg_pkg::CSR_TRIANGLE_SUB, sub);
      csr_wr_en <= 1'b0;
   endtask

   // hold start until the request is taken, then idle at random
   task send_request(logic [cswg_pkg::IDX_W-1:0] idx);
      start <= 1'b1;
      req_sample_index <= idx;
      do @(posedge clock); while (busy);
      sent++;
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task drain();
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (cswg_pkg::LATENCY + 4) @(posedge clock);
   endtask

   function automatic logic [cswg_pkg::IDX_W-1:0] pick_index(
         logic [cswg_pkg::IDX_W-1:0] len);
      int sel;
      sel = $urandom_range(99);
      if (sel < 5) return cswg_pkg::IDX_W'($urandom);
      if (sel < 10) return len;
      if (sel < 13) return '0;
      return cswg_pkg::IDX_W'($urandom_range(0, len));
   endfunction

   initial begin
      logic [cswg_pkg::KIND_W-1:0] kind;
      logic [cswg_pkg::IDX_W-1:0] len, sub;
      int sel;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset configuration: Hamming, N = 64
      send_request('0); send_request(13'd32); send_request(13'd64);
      send_request(13'd65); send_request(13'h1FFF);
      drain();
      write_csr(2'd3, 13'h1FFF);
      csr_wr_en <= 1'b0;
      for (int k = 0; k <= 7; k++) begin
         configure(cswg_pkg::KIND_W'(k), 13'd4096, 13'd4095);
         send_request('0); send_request(13'd2048); send_request(13'd4096);
         drain();
      end
      configure(cswg_pkg::KIND_TRIANGLE, 13'd2, 13'd3);
      send_request('0); send_request(13'd1); send_request(13'd2);
      drain();
      configure(cswg_pkg::KIND_TRIANGLE, 13'd8, 13'd10);
      send_request(13'd4);
      drain();
      configure(cswg_pkg::KIND_TRIANGLE, 13'd0, 13'd0);
      send_request('0);
      drain();
      configure(cswg_pkg::KIND_HANN, 13'd1, 13'd1);
      send_request('0); send_request(13'd1);
      drain();
      configure(cswg_pkg::KIND_BH7, 13'h1FFF, 13'h1FFF);
      send_request(13'd100);
      drain();

      for (int ph = 0; ph < 24; ph++) begin
         case (ph % 4)
            0: idle_pct = 0;
            1: idle_pct = 68;
            2: idle_pct = 0;
            default: idle_pct = 17;
         endcase
         sel = $urandom_range(99);
         kind = (sel < 90) ? cswg_pkg::KIND_W'($urandom_range(0, 5)) :
                             cswg_pkg::KIND_W'($urandom_range(6, 7));
         sel = $urandom_range(99);
         if (sel < 60) len = cswg_pkg::IDX_W'($urandom_range(2, 64));
         else if (sel < 85) len = cswg_pkg::IDX_W'($urandom_range(2, 4096));
         else if (sel < 92) len = 13'd4096;
         else len = cswg_pkg::IDX_W'($urandom);
         sel = $urandom_range(99);
         if (sel < 30) sub = len - 1;
         else if (sel < 60) sub = len;
         else if (sel < 90) sub = len + 1;
         else sub = cswg_pkg::IDX_W'($urandom);
         configure(kind, len, sub);
         repeat (42) send_request(pick_index(len));
         drain();
      end

      $display("covered %0d requests, %0d results (%0d flagged) over all window kinds",
               sent, sb.checked, sb.errs_seen);
      if (sb.mismatches == 0 && sb.pending.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending.size());
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

/* cosine_sum_window_generator.f */
design/cswg_pkg.sv
design/cswg_cos_lane.sv
design/cosine_sum_window_generator.sv
design/cswg_checker.sv
sim/tb.sv
